FILE: hw/rtl/msmgc_pkg.sv
// Package for the masked stereo mix block: widths, register indexes, controller
// states, the sequencer control bundle and the scaling and clamping functions.
// Depends on nothing; every other file of the block imports it.
package msmgc_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int PLANES      = 4;
	localparam int FRAC        = 16;
	localparam int SUM_W       = SAMPLE_BITS + $clog2(PLANES) + 1;
	localparam int GAIN_W      = 18;
	localparam int COEFF_W     = 17;
	localparam int DIFF_W      = GAIN_W + 1;
	localparam int MUL_A_W     = SUM_W;
	localparam int MUL_B_W     = GAIN_W + 1;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int NGAIN_W     = GAIN_W + 3;
	localparam int CNT_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_W       = 18;

	localparam logic [GAIN_W-1:0]  GAIN_MAX   = 18'd131072;
	localparam logic [GAIN_W-1:0]  GAIN_RESET = 18'd32768;
	localparam logic [COEFF_W-1:0] COEFF_MAX  = 17'd65536;
	localparam logic [COEFF_W-1:0] COEFF_RESET = 17'd4226;
	localparam logic [PLANES-1:0]  LEFT_MASK_RESET  = 4'd5;
	localparam logic [PLANES-1:0]  RIGHT_MASK_RESET = 4'd10;

	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [MUL_A_W-1:0] mul_a_t;
	typedef logic signed [MUL_B_W-1:0] mul_b_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [NGAIN_W-1:0] ngain_t;
	typedef logic [SAMPLE_BITS-1:0]    word_t;
	typedef logic [PLANES-1:0][SAMPLE_BITS-1:0] plane_vec_t;

	localparam prod_t  PROD_HI    = prod_t'((1 << (SAMPLE_BITS - 1)) - 1) <<< FRAC;
	localparam prod_t  PROD_LO    = -(prod_t'(1) <<< (SAMPLE_BITS - 1 + FRAC));
	localparam prod_t  PROD_ROUND = prod_t'((1 << FRAC) - 1);
	localparam ngain_t NGAIN_MAX  = ngain_t'(GAIN_MAX);
	localparam word_t  WORD_MAX   = word_t'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam word_t  WORD_MIN   = word_t'(1 << (SAMPLE_BITS - 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_MASK   = 2'd0,
		REG_RIGHT_MASK  = 2'd1,
		REG_TARGET_GAIN = 2'd2,
		REG_SMOOTH_COEF = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN_MUL,
		ST_GAIN_UPD,
		ST_LEFT_MUL,
		ST_RIGHT_MUL,
		ST_RIGHT_POST
	} state_t;

	typedef enum logic [1:0] {
		MSEL_GAIN,
		MSEL_LEFT,
		MSEL_RIGHT
	} mul_sel_t;

	typedef struct packed {
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     gain_upd;
		logic     left_post;
		logic     out_load;
	} ctrl_t;

	typedef struct packed {
		word_t word;
		logic  clip;
	} post_t;

	function automatic sum_t mask_sum(input plane_vec_t pl, input logic [PLANES-1:0] m);
		sum_t acc;
		acc = '0;
		for (int i = 0; i < PLANES; i++) begin
			if (m[i]) begin
				acc = acc + sum_t'($signed(pl[i]));
			end
		end
		return acc;
	endfunction

	// Truncates toward zero and clamps; a value strictly past a bound counts as a clip.
	function automatic post_t scale_post(input prod_t p);
		post_t r;
		prod_t t;
		t = p[PROD_W-1] ? (p + PROD_ROUND) : p;
		t = t >>> FRAC;
		r.clip = 1'b0;
		r.word = t[SAMPLE_BITS-1:0];
		if (p > PROD_HI) begin
			r.word = WORD_MAX;
			r.clip = 1'b1;
		end else if (p < PROD_LO) begin
			r.word = WORD_MIN;
			r.clip = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [GAIN_W-1:0] gain_next(input logic [GAIN_W-1:0] g,
			input prod_t p);
		prod_t  s;
		ngain_t n;
		s = p >>> FRAC;
		n = ngain_t'({3'b000, g}) + s[NGAIN_W-1:0];
		if (n[NGAIN_W-1]) begin
			return '0;
		end else if (n > NGAIN_MAX) begin
			return GAIN_MAX;
		end
		return n[GAIN_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/msmgc_mul.sv
// Shared signed multiplier with a registered product, used for the gain step
// and for both channel scalings. Depends on msmgc_pkg.
module msmgc_mul
	import msmgc_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  mul_a_t a,
	input  mul_b_t b,
	output prod_t  p_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= a * b;
		end
	end

endmodule

FILE: hw/rtl/msmgc_ctrl.sv
// Sequencer that steps one frame through the shared multiplier: optional gain
// step, left product, right product, then the output load. Depends on msmgc_pkg.
module msmgc_ctrl
	import msmgc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  block_start,
	input  logic  out_busy,
	output logic  in_ready,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = block_start ? ST_GAIN_MUL : ST_LEFT_MUL;
				end
			end
			ST_GAIN_MUL:  state_nxt = ST_GAIN_UPD;
			ST_GAIN_UPD:  state_nxt = ST_LEFT_MUL;
			ST_LEFT_MUL:  state_nxt = ST_RIGHT_MUL;
			ST_RIGHT_MUL: state_nxt = ST_RIGHT_POST;
			ST_RIGHT_POST: begin
				if (!out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		ctrl.mul_en    = 1'b0;
		ctrl.mul_sel   = MSEL_GAIN;
		ctrl.gain_upd  = 1'b0;
		ctrl.left_post = 1'b0;
		ctrl.out_load  = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_GAIN_MUL: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MSEL_GAIN;
			end
			ST_GAIN_UPD: ctrl.gain_upd = 1'b1;
			ST_LEFT_MUL: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MSEL_LEFT;
			end
			ST_RIGHT_MUL: begin
				ctrl.mul_en    = 1'b1;
				ctrl.mul_sel   = MSEL_RIGHT;
				ctrl.left_post = 1'b1;
			end
			ST_RIGHT_POST: ctrl.out_load = !out_busy;
			default: in_ready = 1'b0;
		endcase
	end

endmodule

FILE: hw/rtl/masked_stereo_mix_gain_clamp_top.sv
// Top level of the masked stereo mix with smoothed gain and clamping: register
// file, frame capture, datapath and output register. Depends on msmgc_pkg,
// msmgc_mul and msmgc_ctrl.
//
//  channel   handshake            payload
//  s_*       s_tvalid / s_tready  s_tdata (four planes), s_tuser (block_start)
//  m_*       m_tvalid / m_tready  m_tdata (left, right, clip total)
//  cfg_*     cfg_we               cfg_idx, cfg_data
//
// After its transfer a frame steps through the left product, the right product and
// the output load, with a gain product and gain update before them when block_start
// is set. Each product goes once through the single shared multiplier.
// The block takes a new frame only while the sequencer is idle.
// A finished result waits in the output register, and the sequencer holds in its
// last step while that register is still full and not being taken.
// Reset restores the register defaults, the start gain and a zero clip count.
module masked_stereo_mix_gain_clamp_top
	import msmgc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [95:0]          s_tdata,   // plane_a, plane_b, plane_c, plane_d
	input  logic                 s_tuser,   // block_start
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [79:0]          m_tdata,   // left_word, right_word, clip_total
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [PLANES-1:0]  left_mask_q;
	logic [PLANES-1:0]  right_mask_q;
	logic [GAIN_W-1:0]  target_q;
	logic [COEFF_W-1:0] coeff_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [CNT_W-1:0]   clip_cnt_q;
	sum_t               sum_l_q;
	sum_t               sum_r_q;
	diff_t              diff_q;
	word_t              left_word_q;
	logic               left_clip_q;
	logic               out_valid_q;
	logic [79:0]        out_data_q;

	logic [GAIN_W-1:0]  target_sat;
	logic [COEFF_W-1:0] coeff_sat;
	logic               in_fire;
	logic               out_busy;
	ctrl_t              ctrl;
	mul_a_t             mul_a;
	mul_b_t             mul_b;
	prod_t              prod_s1;
	post_t              post;
	logic [CNT_W-1:0]   clip_cnt_nxt;
	plane_vec_t         planes;

	assign planes     = s_tdata;
	assign in_fire    = s_tvalid && s_tready;
	assign out_busy   = out_valid_q && !m_tready;
	assign target_sat = (target_q > GAIN_MAX) ? GAIN_MAX : target_q;
	assign coeff_sat  = (coeff_q > COEFF_MAX) ? COEFF_MAX : coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_mask_q  <= LEFT_MASK_RESET;
			right_mask_q <= RIGHT_MASK_RESET;
			target_q     <= GAIN_RESET;
			coeff_q      <= COEFF_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_LEFT_MASK:   left_mask_q  <= cfg_data[PLANES-1:0];
				REG_RIGHT_MASK:  right_mask_q <= cfg_data[PLANES-1:0];
				REG_TARGET_GAIN: target_q     <= cfg_data[GAIN_W-1:0];
				REG_SMOOTH_COEF: coeff_q      <= cfg_data[COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	msmgc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.block_start(s_tuser),
		.out_busy   (out_busy),
		.in_ready   (s_tready),
		.ctrl       (ctrl)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sum_l_q <= mask_sum(planes, left_mask_q);
			sum_r_q <= mask_sum(planes, right_mask_q);
			diff_q  <= diff_t'({1'b0, target_sat}) - diff_t'({1'b0, gain_q});
		end
	end

	always_comb begin
		case (ctrl.mul_sel)
			MSEL_GAIN: begin
				mul_a = mul_a_t'(diff_q);
				mul_b = mul_b_t'({2'b00, coeff_sat});
			end
			MSEL_LEFT: begin
				mul_a = sum_l_q;
				mul_b = mul_b_t'({1'b0, gain_q});
			end
			MSEL_RIGHT: begin
				mul_a = sum_r_q;
				mul_b = mul_b_t'({1'b0, gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	msmgc_mul u_mul (
		.clk (clk),
		.en  (ctrl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_s1(prod_s1)
	);

	assign post         = scale_post(prod_s1);
	assign clip_cnt_nxt = clip_cnt_q + CNT_W'(left_clip_q) + CNT_W'(post.clip);

	always_ff @(posedge clk) begin
		if (ctrl.left_post) begin
			left_word_q <= post.word;
			left_clip_q <= post.clip;
		end
		if (ctrl.out_load) begin
			out_data_q <= {clip_cnt_nxt, post.word, left_word_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_RESET;
			clip_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.gain_upd) begin
				gain_q <= gain_next(gain_q, prod_s1);
			end
			if (ctrl.out_load) begin
				clip_cnt_q  <= clip_cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= GAIN_MAX)
		else $error("Current gain left its range.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("A new frame was taken while one is in progress.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> !(out_valid_q && !m_tready))
		else $error("A pending result was overwritten.");

	a_clip_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |=> ((clip_cnt_q - $past(clip_cnt_q)) <= CNT_W'(2)))
		else $error("Clip count grew by more than two in one frame.");
`endif

endmodule

FILE: tb/masked_stereo_mix_gain_clamp_top_tb.sv
// Testbench for masked_stereo_mix_gain_clamp_top: drives audio frames and register
// writes, predicts the smoothed gain, masked sums, clamping and clip count, and checks
// every result transfer. Depends on msmgc_pkg and the block's RTL.
`timescale 1ns / 100ps

module masked_stereo_mix_gain_clamp_top_tb;
	import msmgc_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PRINT_CAP   = 40;

	typedef struct {
		plane_vec_t planes;
		logic       block_start;
	} frame_t;

	typedef struct {
		word_t       left;
		word_t       right;
		logic [31:0] clips;
	} mix_t;

	class gain_mix_predictor;
		logic [PLANES-1:0]  left_mask;
		logic [PLANES-1:0]  right_mask;
		logic [GAIN_W-1:0]  target_gain;
		logic [COEFF_W-1:0] smooth_coeff;
		logic [GAIN_W-1:0]  gain;
		logic [31:0]        clips;
		mix_t               pending[$];
		int                 mismatches;
		int                 frames;
		int                 starts;
		int                 checked;

		function new();
			left_mask    = LEFT_MASK_RESET;
			right_mask   = RIGHT_MASK_RESET;
			target_gain  = GAIN_RESET;
			smooth_coeff = COEFF_RESET;
			gain         = GAIN_RESET;
			clips        = '0;
			mismatches   = 0;
			frames       = 0;
			starts       = 0;
			checked      = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_LEFT_MASK:   left_mask    = val[PLANES-1:0];
				REG_RIGHT_MASK:  right_mask   = val[PLANES-1:0];
				REG_TARGET_GAIN: target_gain  = val[GAIN_W-1:0];
				REG_SMOOTH_COEF: smooth_coeff = val[COEFF_W-1:0];
				default: ;
			endcase
		endfunction

		function longint plane_sum(plane_vec_t pl, logic [PLANES-1:0] m);
			longint acc;
			acc = 0;
			for (int p = 0; p < PLANES; p++) begin
				if (m[p]) begin
					acc += longint'($signed(pl[p]));
				end
			end
			return acc;
		endfunction

		// The clip test uses the exact product, so a fractional excess still counts.
		function word_t scale_channel(longint acc);
			longint prod;
			longint hi;
			longint lo;
			longint v;
			hi   = longint'(8388607) * 65536;
			lo   = longint'(-8388608) * 65536;
			prod = acc * longint'(gain);
			if (prod > hi) begin
				v = 8388607;
				clips++;
			end else if (prod < lo) begin
				v = -8388608;
				clips++;
			end else if (prod >= 0) begin
				v = prod >>> 16;
			end else begin
				v = -((-prod) >>> 16);
			end
			return word_t'(v);
		endfunction

		function void note_frame(frame_t f);
			longint tgt;
			longint cf;
			longint cur;
			mix_t   r;
			frames++;
			if (f.block_start) begin
				starts++;
				tgt = (target_gain > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(target_gain);
				cf  = (smooth_coeff > COEFF_MAX) ? longint'(COEFF_MAX) : longint'(smooth_coeff);
				cur = longint'(gain);
				cur += (cf * (tgt - cur)) >>> 16;
				if (cur < 0) begin
					cur = 0;
				end
				if (cur > longint'(GAIN_MAX)) begin
					cur = longint'(GAIN_MAX);
				end
				gain = cur[GAIN_W-1:0];
			end
			r.left  = scale_channel(plane_sum(f.planes, left_mask));
			r.right = scale_channel(plane_sum(f.planes, right_mask));
			r.clips = clips;
			pending.push_back(r);
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			mismatches++;
			if (mismatches <= PRINT_CAP) begin
				$display("Mismatch at result %0d, %s: got 0x%0h, expected 0x%0h.",
					checked, what, got, want);
			end
		endtask

		task check_mix(logic [79:0] data);
			mix_t got;
			mix_t want;
			got.left  = data[23:0];
			got.right = data[47:24];
			got.clips = data[79:48];
			if (pending.size() == 0) begin
				report("transfer with no frame pending", data[47:0], 0);
			end else begin
				want = pending.pop_front();
				if (got.left !== want.left) begin
					report("left_word", got.left, want.left);
				end
				if (got.right !== want.right) begin
					report("right_word", got.right, want.right);
				end
				if (got.clips !== want.clips) begin
					report("clip_total", got.clips, want.clips);
				end
			end
			checked++;
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [95:0]          s_tdata;   // plane_a, plane_b, plane_c, plane_d
	logic                 s_tuser;   // block_start
	logic                 m_tvalid;
	logic                 m_tready;
	logic [79:0]          m_tdata;   // left_word, right_word, clip_total
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	gain_mix_predictor mix_predictor = new();
	bit src_gaps  = 1'b1;
	bit sink_gaps = 1'b1;
	int sink_hold = 0;
	int settings  = 0;

	masked_stereo_mix_gain_clamp_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return $urandom_range(10, 40);
		end else if (r < 9) begin
			return 0;
		end
		return $urandom_range(1, 5);
	endfunction

	function automatic word_t rand_sample();
		case ($urandom_range(0, 7))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return word_t'($urandom_range(0, 511) - 256);
			default: return word_t'($urandom());
		endcase
	endfunction

	function automatic frame_t make_frame(input word_t a, input word_t b, input word_t c,
			input word_t d, input logic bs);
		frame_t f;
		f.planes      = {d, c, b, a};
		f.block_start = bs;
		return f;
	endfunction

	function automatic logic [GAIN_W-1:0] pick_target();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return GAIN_MAX;
			2: return '1;
			3: return GAIN_W'($urandom_range(131073, 262143));
			default: return GAIN_W'($urandom_range(0, 131072));
		endcase
	endfunction

	function automatic logic [COEFF_W-1:0] pick_coeff();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return COEFF_MAX;
			2: return COEFF_W'($urandom_range(65537, 131071));
			3: return COEFF_W'($urandom_range(1, 64));
			default: return COEFF_W'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		mix_predictor.set_reg(idx, val);
	endtask

	task automatic program_regs(input logic [PLANES-1:0] lm, input logic [PLANES-1:0] rm,
			input logic [GAIN_W-1:0] tg, input logic [COEFF_W-1:0] sc);
		put_reg(REG_LEFT_MASK, CFG_W'(lm));
		put_reg(REG_RIGHT_MASK, CFG_W'(rm));
		put_reg(REG_TARGET_GAIN, CFG_W'(tg));
		put_reg(REG_SMOOTH_COEF, CFG_W'(sc));
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic send_frame(input frame_t f);
		int gap;
		s_tdata  <= f.planes;
		s_tuser  <= f.block_start;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		mix_predictor.note_frame(f);
		gap = src_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_mixes();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (mix_predictor.pending.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : sink
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				mix_predictor.check_mix(m_tdata);
			end
			if (sink_hold > 0) begin
				stall     = sink_hold;
				sink_hold = 0;
			end else if (stall == 0 && sink_gaps && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("No transfer for %0d cycles, run stopped.", quiet);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		frame_t f;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		m_tready <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_idx  <= REG_LEFT_MASK;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: gain one half, left takes planes a and c, right b and d.
		send_frame(make_frame('0, '0, '0, '0, 1'b0));
		send_frame(make_frame(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1));
		send_frame(make_frame(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0));
		send_frame(make_frame(-24'sd1, 24'sd1, -24'sd3, 24'sd3, 1'b0));
		wait_for_mixes();

		// A full-rate coefficient lands the gain just above unity.
		program_regs(4'hF, 4'h0, 18'd65537, COEFF_MAX);
		send_frame(make_frame(WORD_MAX, '0, '0, '0, 1'b1));
		send_frame(make_frame(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0));
		send_frame(make_frame(-24'sd1, -24'sd1, '0, '0, 1'b0));
		wait_for_mixes();

		// Target and coefficient beyond their ranges saturate where they are used.
		program_regs(4'hF, 4'hF, '1, '1);
		send_frame(make_frame(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1));
		send_frame(make_frame(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0));
		send_frame(make_frame(24'sd1, '0, '0, '0, 1'b0));
		wait_for_mixes();

		program_regs(4'h1, 4'h8, '0, COEFF_MAX);
		send_frame(make_frame(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1));
		wait_for_mixes();
		program_regs(4'h1, 4'h8, GAIN_MAX, '0);
		send_frame(make_frame(WORD_MAX, '0, '0, WORD_MIN, 1'b1));
		wait_for_mixes();
		program_regs(4'h3, 4'hC, GAIN_MAX, 17'd1);
		send_frame(make_frame(WORD_MAX, '0, WORD_MIN, '0, 1'b1));
		wait_for_mixes();

		// A negative step rounds toward minus infinity.
		program_regs(4'h3, 4'hC, '0, 17'd1);
		send_frame(make_frame(WORD_MIN, '0, WORD_MAX, '0, 1'b1));
		send_frame(make_frame(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1));
		wait_for_mixes();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				program_regs(LEFT_MASK_RESET, RIGHT_MASK_RESET, GAIN_RESET, COEFF_RESET);
			end else begin
				program_regs(PLANES'($urandom_range(0, 15)), PLANES'($urandom_range(0, 15)),
					pick_target(), pick_coeff());
			end
			src_gaps  = (ph % 4 == 0) || (ph % 4 == 3);
			sink_gaps = (ph % 4 == 0) || (ph % 4 == 2);
			if (ph == 2) begin
				sink_hold = 400;
			end
			for (int n = 0; n < 100; n++) begin
				f = make_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
					$urandom_range(0, 5) == 0);
				send_frame(f);
				if ($urandom_range(0, 49) == 0) begin
					wait_for_mixes();
				end
			end
			wait_for_mixes();
		end

		repeat (20) @(posedge clk);
		$display("Sent %0d frames (%0d starting a block) under %0d register settings.",
			mix_predictor.frames, mix_predictor.starts, settings);
		$display("Checked %0d results; clip count reached %0d; %0d mismatches.",
			mix_predictor.checked, mix_predictor.clips, mix_predictor.mismatches);
		if (mix_predictor.mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
